>>> rtl/wos_pkg.sv
// Shared types, codes and the sine table function for the waveform oscillator.
`timescale 1ns / 1ps
package wos_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_LOOK,
    S_SHAPE,
    S_MIX
  } state_t;

  localparam logic [2:0] WAVE_SINE   = 3'd0;
  localparam logic [2:0] WAVE_TRI    = 3'd1;
  localparam logic [2:0] WAVE_SQUARE = 3'd2;
  localparam logic [2:0] WAVE_SAW    = 3'd3;
  localparam logic [2:0] WAVE_NOISE  = 3'd4;

  localparam logic [15:0] DUTY_RESET = 16'd45875;
  localparam logic [15:0] LFSR_SEED  = 16'hACE1;
  localparam logic [15:0] LFSR_TAPS  = 16'hB400;
  localparam int          GAIN_BITS  = 10;

  localparam longint unsigned Q30_ONE     = 64'd1 << 30;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef struct packed {
    logic load_in;
    logic do_mul;
    logic do_look;
    logic do_shape;
    logic do_out;
  } dp_cmd_t;

  typedef struct packed {
    logic out_hold;
  } dp_status_t;

  // sin(pi/2 * k / 2^(aw-2)) in Q30, Taylor series to x^11, truncating products.
  // Evaluated at elaboration only.
  function automatic logic [31:0] sine_q30(int unsigned k, int unsigned aw);
    longint unsigned r;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    r  = 64'(k) << (32 - aw);
    x  = (r * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - ((x2 * t) >> 30) / 110;
    t  = Q30_ONE - ((x2 * t) >> 30) / 72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 6;
    return 32'((x * t) >> 30);
  endfunction

endpackage

>>> rtl/wos_ctrl.sv
// Sequencing state machine for the waveform oscillator.
`timescale 1ns / 1ps
module wos_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output wos_pkg::dp_cmd_t    cmd,
  input  wos_pkg::dp_status_t status
);

  wos_pkg::state_t state;
  wos_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wos_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      wos_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = wos_pkg::S_MUL;
        end
      end
      wos_pkg::S_MUL: begin
        cmd.do_mul = 1'b1;
        state_next = wos_pkg::S_LOOK;
      end
      wos_pkg::S_LOOK: begin
        cmd.do_look = 1'b1;
        state_next  = wos_pkg::S_SHAPE;
      end
      wos_pkg::S_SHAPE: begin
        cmd.do_shape = 1'b1;
        state_next   = wos_pkg::S_MIX;
      end
      wos_pkg::S_MIX: begin
        // wait here while the previous result still sits unclaimed
        if (!status.out_hold) begin
          cmd.do_out = 1'b1;
          state_next = wos_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = wos_pkg::S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/wos_dp.sv
// Datapath: phase multiply, sine table, waveform shaping, noise gain, output register.
`timescale 1ns / 1ps
module wos_dp #(
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int PHASE_BITS       = 32,
  parameter int SAMPLE_BITS      = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  wos_pkg::dp_cmd_t              cmd,
  output wos_pkg::dp_status_t           status,
  input  logic                          cfg_write,
  input  logic [15:0]                   square_duty,
  input  logic [2:0]                    waveform,
  input  logic [31:0]                   phase_step,
  input  logic [31:0]                   start_count,
  input  logic [31:0]                   now_count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] sample
);

  localparam int AW  = $clog2(SINE_TABLE_DEPTH);
  localparam int QAW = AW - 2;
  localparam int QD  = SINE_TABLE_DEPTH / 4;
  localparam int SB  = SAMPLE_BITS;
  localparam int MB  = SB - 1;
  localparam int SH  = PHASE_BITS - (SB - 1);
  localparam int TW  = PHASE_BITS + 3;
  localparam int RW  = (SH > 0) ? TW + 1 : TW + 1 - SH;
  localparam int SSH = 30 - (SB - 1);
  localparam int GB  = wos_pkg::GAIN_BITS;

  localparam logic signed [SB-1:0] SMAX   = SB'(2 ** (SB - 1) - 1);
  localparam logic signed [SB-1:0] SMIN   = ~SMAX;
  localparam logic signed [RW-1:0] RMAX   = RW'(2 ** (SB - 1) - 1);
  localparam logic signed [RW-1:0] RMIN   = ~RMAX;
  localparam logic signed [33:0]   SNMAX  = 34'(2 ** (SB - 1) - 1);
  localparam logic signed [33:0]   SNMIN  = ~SNMAX;
  localparam logic signed [33:0]   SNHALF = 34'sd1 <<< (SSH - 1);
  localparam logic signed [TW-1:0] ONE_T  = TW'(64'd1 << PHASE_BITS);

  // quarter-wave table: address a holds sin for quarter index a+1
  logic [31:0] qtab [QD];
  for (genvar g = 0; g < QD; g++) begin : g_qtab
    assign qtab[g] = wos_pkg::sine_q30(32'(g + 1), AW);
  end

  logic [2:0]                   wave_r;
  logic [31:0]                  step_r;
  logic [31:0]                  delta_r;
  logic [63:0]                  prod;
  logic [15:0]                  duty_r;
  logic [15:0]                  lfsr;
  logic [31:0]                  rom_q;
  logic                         sin_zero;
  logic                         sin_neg;
  logic                         sq_hi;
  logic signed [TW-1:0]         shape_t;
  logic signed [SB-1:0]         shape_r;
  logic signed [SB-1:0]         sine_r;

  logic [PHASE_BITS-1:0]        phase;
  logic [AW-1:0]                idx;
  logic [QAW-1:0]               jj;
  logic [QAW-1:0]               rom_addr;
  logic signed [TW-1:0]         p4;
  logic signed [TW-1:0]         tri_t;
  logic signed [TW-1:0]         saw_t;
  logic [PHASE_BITS-1:0]        duty_ext;
  logic [15:0]                  lfsr_next;
  logic signed [RW-1:0]         shape_rr;
  logic signed [SB-1:0]         shape_sat;
  logic signed [33:0]           sin_s;
  logic signed [33:0]           sin_rnd;
  logic signed [SB-1:0]         sine_sat;
  logic signed [SB-1:0]         neg_s;
  logic signed [SB-1:0]         abs_s;
  logic [MB+GB-1:0]             noise_prod;
  logic signed [SB-1:0]         mix_v;

  assign phase    = prod[PHASE_BITS-1:0];
  assign idx      = phase[PHASE_BITS-1 -: AW];
  assign jj       = idx[QAW-1:0];
  assign rom_addr = idx[AW-2] ? ~jj : jj - QAW'(1);
  assign p4       = $signed({3'b000, phase}) <<< 2;
  assign duty_ext = PHASE_BITS'(duty_r) << (PHASE_BITS - 16);
  assign lfsr_next = {1'b0, lfsr[15:1]} ^ (lfsr[0] ? wos_pkg::LFSR_TAPS : 16'd0);

  always_comb begin
    case (phase[PHASE_BITS-1 -: 2])
      2'b00:   tri_t = p4;
      2'b11:   tri_t = p4 - (ONE_T <<< 2);
      default: tri_t = (ONE_T <<< 1) - p4;
    endcase
    if (phase[PHASE_BITS-1]) begin
      saw_t = (p4 >>> 1) - (ONE_T <<< 1);
    end else begin
      saw_t = p4 >>> 1;
    end
  end

  // round half up (floor of t + half) to the sample scale; shift left instead when SH <= 0
  if (SH > 0) begin : g_rnd
    localparam logic signed [RW-1:0] HALF = RW'(64'd1 << (SH - 1));
    assign shape_rr = ($signed({{(RW - TW){shape_t[TW-1]}}, shape_t}) + HALF) >>> SH;
  end else begin : g_shl
    assign shape_rr = $signed({{(RW - TW){shape_t[TW-1]}}, shape_t}) <<< (-SH);
  end

  always_comb begin
    if (shape_rr > RMAX) begin
      shape_sat = SMAX;
    end else if (shape_rr < RMIN) begin
      shape_sat = SMIN;
    end else begin
      shape_sat = shape_rr[SB-1:0];
    end
  end

  always_comb begin
    if (sin_zero) begin
      sin_s = '0;
    end else if (sin_neg) begin
      sin_s = -$signed({2'b00, rom_q});
    end else begin
      sin_s = $signed({2'b00, rom_q});
    end
    sin_rnd = (sin_s + SNHALF) >>> SSH;
    if (sin_rnd > SNMAX) begin
      sine_sat = SMAX;
    end else if (sin_rnd < SNMIN) begin
      sine_sat = SMIN;
    end else begin
      sine_sat = sin_rnd[SB-1:0];
    end
  end

  assign neg_s = -sine_r;
  always_comb begin
    if (sine_r == SMIN) begin
      abs_s = SMAX;
    end else if (sine_r[SB-1]) begin
      abs_s = neg_s;
    end else begin
      abs_s = sine_r;
    end
  end
  assign noise_prod = abs_s[MB-1:0] * lfsr[GB-1:0];

  always_comb begin
    case (wave_r)
      wos_pkg::WAVE_SINE:   mix_v = sine_r;
      wos_pkg::WAVE_TRI:    mix_v = shape_r;
      wos_pkg::WAVE_SAW:    mix_v = shape_r;
      wos_pkg::WAVE_SQUARE: mix_v = sq_hi ? SMAX : SMIN;
      wos_pkg::WAVE_NOISE:  mix_v = $signed({1'b0, noise_prod[MB+GB-1:GB]});
      default:              mix_v = '0;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      duty_r    <= wos_pkg::DUTY_RESET;
      lfsr      <= wos_pkg::LFSR_SEED;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        duty_r <= square_duty;
      end
      if (cmd.do_look && wave_r == wos_pkg::WAVE_NOISE) begin
        lfsr <= lfsr_next;
      end
      if (cmd.do_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      wave_r  <= waveform;
      step_r  <= phase_step;
      delta_r <= now_count - start_count;
    end
    if (cmd.do_mul) begin
      prod <= step_r * delta_r;
    end
    if (cmd.do_look) begin
      rom_q    <= qtab[rom_addr];
      sin_zero <= ~idx[AW-2] & (jj == '0);
      sin_neg  <= idx[AW-1];
      sq_hi    <= phase < duty_ext;
      shape_t  <= (wave_r == wos_pkg::WAVE_SAW) ? saw_t : tri_t;
    end
    if (cmd.do_shape) begin
      shape_r <= shape_sat;
      sine_r  <= sine_sat;
    end
    if (cmd.do_out) begin
      sample <= mix_v;
    end
  end

  assign status.out_hold = out_valid & ~out_ready;

endmodule

>>> rtl/waveform_oscillator_sample.sv
// Top level of the waveform oscillator: one Q1.15 sample per input item.
`timescale 1ns / 1ps
// An accepted item runs through the controller's step sequence (32x32 phase
//   multiply, table read, rounding, gain and select) before out_valid rises;
//   no new item is accepted until the sequencer is back in idle.
// A result waiting at the output holds the sequencer in its last step only.
// Reset (rst, sync, active high): controller idle, output empty, noise LFSR
//   back to its seed, square duty back to 0.70.
module waveform_oscillator_sample #(
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int PHASE_BITS       = 32,
  parameter int SAMPLE_BITS      = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration: square duty, written whenever cfg_write is high
  input  logic                          cfg_write,
  input  logic [15:0]                   square_duty,
  // input item
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    waveform,
  input  logic [31:0]                   phase_step,
  input  logic [31:0]                   start_count,
  input  logic [31:0]                   now_count,
  // result item
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] sample
);

  // Command and status between the sequencer and the datapath.
  wos_pkg::dp_cmd_t    cmd;
  wos_pkg::dp_status_t status;

  // Sequencer: idle -> multiply -> table lookup -> round -> mix/out.
  wos_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .status   (status)
  );

  // Datapath: phase = low PHASE_BITS of step * (now - start), sine from a
  // quarter-wave table, triangle/sawtooth rounded half up and saturated,
  // square against the duty, noise as |sine| scaled by a 10-bit LFSR gain.
  wos_dp #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .PHASE_BITS       (PHASE_BITS),
    .SAMPLE_BITS      (SAMPLE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_write   (cfg_write),
    .square_duty (square_duty),
    .waveform    (waveform),
    .phase_step  (phase_step),
    .start_count (start_count),
    .now_count   (now_count),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .sample      (sample)
  );

endmodule

>>> rtl/wos_chk.sv
// Port-level checks for the waveform oscillator, bound to the top level.
`timescale 1ns / 1ps
module wos_chk #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [SAMPLE_BITS-1:0] sample
);

  // a result not taken stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample))
    else $error("result changed or dropped while stalled");

  // one item in flight: no second accept right after the first
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while another is in work");

  // a new result cannot appear early, before the accepted item has passed the multiply, lookup and round steps
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> ##1 !$rose(out_valid) ##1 !$rose(out_valid)
      ##1 !$rose(out_valid))
    else $error("result appeared too early");

endmodule

bind waveform_oscillator_sample wos_chk #(.SAMPLE_BITS(SAMPLE_BITS)) u_chk (.*);
